@@ rtl/mdu_pkg.sv @@
// Shared types, operation codes and helpers for the RV64M multiply/divide unit.
`default_nettype none
package mdu_pkg;

  localparam int XLEN   = 64;
  localparam int NCELLS = XLEN;

  typedef enum logic [3:0] {
    MODE_MUL    = 4'd0,
    MODE_MULH   = 4'd1,
    MODE_MULHSU = 4'd2,
    MODE_MULHU  = 4'd3,
    MODE_DIV    = 4'd4,
    MODE_DIVU   = 4'd5,
    MODE_REM    = 4'd6,
    MODE_REMU   = 4'd7,
    MODE_MULW   = 4'd8,
    MODE_DIVW   = 4'd9,
    MODE_DIVUW  = 4'd10,
    MODE_REMW   = 4'd11,
    MODE_REMUW  = 4'd12
  } mode_t;

  typedef struct packed {
    logic [3:0] mode;    // raw code, unused codes kept for zero result
    logic       is_div;
    logic       neg_lo;  // negate product, or negate quotient
    logic       neg_hi;  // negate remainder
    logic       dz;      // divisor is zero
  } ctl_t;

  typedef struct packed {
    logic [XLEN-1:0] hi;
    logic [XLEN-1:0] lo;
    logic [XLEN-1:0] d;
    logic [XLEN-1:0] a_orig;
    ctl_t            ctl;
  } stage_t;

  function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/mdu_in_if.sv @@
// Input channel: operation code and two source operands.
`default_nettype none
interface mdu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

@@ rtl/mdu_out_if.sv @@
// Output channel: 64-bit destination value.
`default_nettype none
interface mdu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface
`default_nettype wire

@@ rtl/rv64m_multiply_divide_unit_core.sv @@
// RV64M multiply/divide unit: operand prep, chain of 64 cells, result stage.
//
// Usage:
//   in_ch  (sink):   mode, operand_a, operand_b; a beat moves on valid && ready.
//   out_ch (source): result; one beat for every input beat, in order.
//   Multiplies run a shift-add chain, divides a restoring chain, both through
//   the same row of 64 cells, one operand bit per cell.
// Each beat runs through the 64 cells and then the output register;
//   throughput is one beat per cycle while the receiver takes results.
// Each cell advances when its downstream neighbor is empty or moving, so
//   bubbles in the chain close up while the receiver stalls, and new beats
//   are taken until every cell holds an item. A full chain stalls in place
//   and drops nothing.
// Reset (rst, synchronous) empties every cell and the output register; no
//   payload is cleared.
`default_nettype none
module rv64m_multiply_divide_unit_core import mdu_pkg::*; (
  input logic       clk,
  input logic       rst,
  mdu_in_if.sink    in_ch,
  mdu_out_if.source out_ch
);
  stage_t pipe [0:NCELLS];
  logic   vld  [0:NCELLS];
  logic   rdy  [0:NCELLS];

  mdu_prep u_prep (
    .mode      (in_ch.mode),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .seed      (pipe[0])
  );

  assign vld[0]      = in_ch.valid;
  assign in_ch.ready = rdy[0];

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    mdu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (vld[i]),
      .in_data    (pipe[i]),
      .up_ready   (rdy[i]),
      .out_valid  (vld[i+1]),
      .out_data   (pipe[i+1]),
      .down_ready (rdy[i+1])
    );
  end

  mdu_post u_post (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NCELLS]),
    .in_data  (pipe[NCELLS]),
    .up_ready (rdy[NCELLS]),
    .out_ch   (out_ch)
  );

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> vld[1])
    else $error("accepted beat did not enter first cell");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !vld[1] |-> in_ch.ready)
    else $error("input stalled with empty first cell");

  a_tail_drains: assert property (@(posedge clk) disable iff (rst)
    vld[NCELLS] && !out_ch.valid |=> out_ch.valid)
    else $error("last cell did not move into empty output register");

endmodule
`default_nettype wire

@@ rtl/mdu_prep.sv @@
// Operand conditioning: word extension, sign magnitudes and chain seed.
`default_nettype none
module mdu_prep import mdu_pkg::*; (
  input  logic [3:0]      mode,
  input  logic [XLEN-1:0] operand_a,
  input  logic [XLEN-1:0] operand_b,
  output stage_t          seed
);
  logic            word, sgn_a, sgn_b, is_div, sa, sb;
  logic [XLEN-1:0] a64, b64, ma, mb;

  always_comb begin
    word   = 1'b0;
    sgn_a  = 1'b0;
    sgn_b  = 1'b0;
    is_div = 1'b0;
    case (mode)
      MODE_MULH:             begin sgn_a = 1'b1; sgn_b = 1'b1; end
      MODE_MULHSU:           sgn_a = 1'b1;
      MODE_DIV, MODE_REM:    begin is_div = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1; end
      MODE_DIVU, MODE_REMU:  is_div = 1'b1;
      MODE_MULW:             word = 1'b1;
      MODE_DIVW, MODE_REMW:  begin
        word = 1'b1; is_div = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1;
      end
      MODE_DIVUW, MODE_REMUW: begin word = 1'b1; is_div = 1'b1; end
      default: ;
    endcase

    if (word && sgn_a) begin
      a64 = sx32(operand_a);
      b64 = sx32(operand_b);
    end else if (word && is_div) begin
      a64 = {32'd0, operand_a[31:0]};
      b64 = {32'd0, operand_b[31:0]};
    end else begin
      a64 = operand_a;
      b64 = operand_b;
    end

    sa = sgn_a & a64[XLEN-1];
    sb = sgn_b & b64[XLEN-1];
    ma = sa ? (~a64 + 1'b1) : a64;
    mb = sb ? (~b64 + 1'b1) : b64;

    seed.hi         = '0;
    seed.a_orig     = a64;
    seed.ctl.mode   = mode;
    seed.ctl.is_div = is_div;
    seed.ctl.neg_lo = sa ^ sb;
    seed.ctl.neg_hi = sa;
    seed.ctl.dz     = (b64 == '0);
    if (is_div) begin
      seed.lo = ma;
      seed.d  = mb;
    end else begin
      seed.lo = mb;
      seed.d  = ma;
    end
  end
endmodule
`default_nettype wire

@@ rtl/mdu_cell.sv @@
// One chain cell: a shift-add multiply step or a restoring divide step.
`default_nettype none
module mdu_cell import mdu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   up_ready,
  output logic   out_valid,
  output stage_t out_data,
  input  logic   down_ready
);
  stage_t      step;
  logic [XLEN:0]   sum;
  logic [XLEN+1:0] diff;
  logic            ge;

  assign up_ready = !out_valid || down_ready;

  always_comb begin
    step = in_data;
    sum  = {1'b0, in_data.hi} + (in_data.lo[0] ? {1'b0, in_data.d} : '0);
    diff = {1'b0, in_data.hi, in_data.lo[XLEN-1]} - {2'b00, in_data.d};
    ge   = !diff[XLEN+1];
    if (in_data.ctl.is_div) begin
      // keep the trial difference when it does not go negative
      step.hi = ge ? diff[XLEN-1:0] : {in_data.hi[XLEN-2:0], in_data.lo[XLEN-1]};
      step.lo = {in_data.lo[XLEN-2:0], ge};
    end else begin
      step.hi = sum[XLEN:1];
      step.lo = {sum[0], in_data.lo[XLEN-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      out_data <= step;
    end
  end
endmodule
`default_nettype wire

@@ rtl/mdu_post.sv @@
// Result stage: sign fix-up, special cases, word extension and output register.
`default_nettype none
module mdu_post import mdu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   up_ready,
  mdu_out_if.source out_ch
);
  logic [2*XLEN-1:0] prod;
  logic [XLEN-1:0]   q, r, res;

  assign up_ready = !out_ch.valid || out_ch.ready;

  always_comb begin
    prod = {in_data.hi, in_data.lo};
    if (in_data.ctl.neg_lo) prod = ~prod + 1'b1;
    q = in_data.ctl.neg_lo ? (~in_data.lo + 1'b1) : in_data.lo;
    r = in_data.ctl.neg_hi ? (~in_data.hi + 1'b1) : in_data.hi;
    if (in_data.ctl.dz) begin
      q = '1;
      r = in_data.a_orig;
    end
    case (in_data.ctl.mode)
      MODE_MUL:                           res = prod[XLEN-1:0];
      MODE_MULH, MODE_MULHSU, MODE_MULHU: res = prod[2*XLEN-1:XLEN];
      MODE_DIV, MODE_DIVU:                res = q;
      MODE_REM, MODE_REMU:                res = r;
      MODE_MULW:                          res = sx32(prod[XLEN-1:0]);
      MODE_DIVW, MODE_DIVUW:              res = sx32(q);
      MODE_REMW, MODE_REMUW:              res = sx32(r);
      default:                            res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (up_ready) begin
      out_ch.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      out_ch.result <= res;
    end
  end
endmodule
`default_nettype wire
